FILE: rtl/dsa_pkg.sv
// Shared types and constants for the descriptor slot allocator.
// Used by dsa_ctrl, dsa_datapath, the top level and the checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsa_pkg;

  // Table geometry.
  localparam int SLOTS       = 64;
  localparam int CONTEXTS    = 8;
  localparam int HANDLE_BITS = 32;

  // Field widths of the request and result ports.
  localparam int CMD_W     = 3;
  localparam int CTXF_W    = 3;
  localparam int SLOTF_W   = 6;
  localparam int HANDLEF_W = 32;
  localparam int STATUS_W  = 2;

  // Derived internal widths.
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CTX_W     = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int ADDR_W    = CTX_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // The free-slot search works on groups of eight bits.
  localparam int GROUP_W = 8;
  localparam int GROUPS  = (SLOTS + GROUP_W - 1) / GROUP_W;
  localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int ROW_W   = GROUPS * GROUP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC         = 3'd0,
    CMD_RESERVE       = 3'd1,
    CMD_RELEASE       = 3'd2,
    CMD_INSTALL       = 3'd3,
    CMD_LOOKUP        = 3'd4,
    CMD_ALLOC_INSTALL = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BUSY = 2'd2,
    ST_BADF = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // take the request and the context's occupancy row
    logic find;        // pick the target slot and read its handle
    logic commit;      // update the tables and load the result register
    logic clear_step;  // zero one handle memory entry
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing sweep is at its last entry
    logic out_stall;   // the result register is full and not being taken
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/dsa_ctrl.sv
// Sequencing state machine of the descriptor slot allocator.
// Depends on dsa_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module dsa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dsa_pkg::dp_stat_t stat_i,
  output dsa_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DONE
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == S_IDLE) && ready_q && in_valid_i;
    cmd_o.find       = (state_q == S_READ);
    cmd_o.commit     = (state_q == S_DONE) && !stat_i.out_stall;
    cmd_o.clear_step = (state_q == S_CLEAR);
  end

  assign in_ready_o = ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ready_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (stat_i.clear_last) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i && ready_q) begin
            state_q <= S_READ;
            ready_q <= 1'b0;
          end
        end
        S_READ: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!stat_i.out_stall) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_CLEAR;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsa_datapath.sv
// Datapath of the descriptor slot allocator: request registers, occupancy bitmaps,
// lowest-free search, handle memory and result register. Depends on dsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsa_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dsa_pkg::dp_cmd_t                  cmd_i,
  output dsa_pkg::dp_stat_t                      stat_o,
  input  wire logic [dsa_pkg::CMD_W-1:0]         command_i,
  input  wire logic [dsa_pkg::CTXF_W-1:0]        context_req_i,
  input  wire logic [dsa_pkg::SLOTF_W-1:0]       slot_in_i,
  input  wire logic [dsa_pkg::HANDLEF_W-1:0]     handle_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [dsa_pkg::STATUS_W-1:0]           status_o,
  output logic [dsa_pkg::SLOTF_W-1:0]            slot_out_o,
  output logic [dsa_pkg::HANDLEF_W-1:0]          handle_out_o,
  output logic [dsa_pkg::HANDLEF_W-1:0]          prior_handle_o
);

  // Request registers.
  dsa_pkg::cmd_e                    cmd_q;
  logic                             ctx_ok_q;
  logic [dsa_pkg::CTX_W-1:0]        ctx_q;
  logic [dsa_pkg::SLOTF_W-1:0]      slot_in_q;
  logic [dsa_pkg::HANDLE_BITS-1:0]  hin_q;
  logic [dsa_pkg::ROW_W-1:0]        row_q;
  logic [dsa_pkg::GROUPS-1:0]       gfree_q;

  // Search results.
  logic [dsa_pkg::SLOT_W-1:0]       tgt_d, tgt_q;
  logic                             full_q;
  logic [dsa_pkg::HANDLE_BITS-1:0]  rd_q;

  // Tables.
  logic [dsa_pkg::SLOTS-1:0]        occ_q [dsa_pkg::CONTEXTS];
  logic [dsa_pkg::HANDLE_BITS-1:0]  handle_mem [dsa_pkg::MEM_DEPTH];
  logic [dsa_pkg::ADDR_W-1:0]       clr_cnt_q;

  // Result register.
  logic                             out_valid_q;
  dsa_pkg::status_e                 status_q;
  logic [dsa_pkg::SLOTF_W-1:0]      slot_out_q;
  logic [dsa_pkg::HANDLEF_W-1:0]    handle_out_q;
  logic [dsa_pkg::HANDLEF_W-1:0]    prior_q;

  logic [dsa_pkg::CTX_W-1:0]        ctx_idx;
  logic [dsa_pkg::ROW_W-1:0]        row_pad;
  logic [dsa_pkg::GRP_W-1:0]        gsel;
  logic [dsa_pkg::GROUP_W-1:0]      gbits;
  logic [2:0]                       bsel;
  logic [dsa_pkg::SLOT_W-1:0]       found;
  logic                             is_alloc;

  // Commit-time decisions.
  dsa_pkg::status_e                 st_d;
  logic [dsa_pkg::SLOTF_W-1:0]      sout_d;
  logic [dsa_pkg::HANDLEF_W-1:0]    hout_d;
  logic [dsa_pkg::HANDLEF_W-1:0]    prior_d;
  logic                             set_bit, clr_bit, mem_we;
  logic [dsa_pkg::HANDLE_BITS-1:0]  wdata;
  logic                             slot_ok, used, hin_zero;

  assign ctx_idx = dsa_pkg::CTX_W'(context_req_i);

  always_comb begin
    row_pad                        = '1;
    row_pad[dsa_pkg::SLOTS-1:0]    = occ_q[ctx_idx];
  end

  // Two short priority picks: lowest group with a free bit, then the lowest
  // free bit inside that group.
  always_comb begin
    gsel = '0;
    for (int g = dsa_pkg::GROUPS - 1; g >= 0; g--) begin
      if (gfree_q[g]) gsel = dsa_pkg::GRP_W'(g);
    end
    gbits = row_q[gsel * dsa_pkg::GROUP_W +: dsa_pkg::GROUP_W];
    bsel  = '0;
    for (int b = dsa_pkg::GROUP_W - 1; b >= 0; b--) begin
      if (!gbits[b]) bsel = 3'(b);
    end
    found    = dsa_pkg::SLOT_W'({gsel, bsel});
    is_alloc = (cmd_q == dsa_pkg::CMD_ALLOC) || (cmd_q == dsa_pkg::CMD_ALLOC_INSTALL);
    tgt_d    = is_alloc ? found : dsa_pkg::SLOT_W'(slot_in_q);
  end

  always_comb begin
    slot_ok  = int'(slot_in_q) < dsa_pkg::SLOTS;
    used     = row_q[tgt_q];
    hin_zero = (hin_q == '0);
    st_d     = dsa_pkg::ST_BADF;
    sout_d   = '0;
    hout_d   = '0;
    prior_d  = '0;
    set_bit  = 1'b0;
    clr_bit  = 1'b0;
    mem_we   = 1'b0;
    wdata    = hin_q;
    if (ctx_ok_q) begin
      case (cmd_q)
        dsa_pkg::CMD_ALLOC: begin
          if (full_q) begin
            st_d = dsa_pkg::ST_FULL;
          end else begin
            st_d    = dsa_pkg::ST_OK;
            set_bit = 1'b1;
            sout_d  = dsa_pkg::SLOTF_W'(tgt_q);
          end
        end
        dsa_pkg::CMD_ALLOC_INSTALL: begin
          if (hin_zero) begin
            st_d = dsa_pkg::ST_BADF;
          end else if (full_q) begin
            st_d = dsa_pkg::ST_FULL;
          end else begin
            st_d    = dsa_pkg::ST_OK;
            set_bit = 1'b1;
            mem_we  = 1'b1;
            sout_d  = dsa_pkg::SLOTF_W'(tgt_q);
            prior_d = dsa_pkg::HANDLEF_W'(rd_q);
          end
        end
        dsa_pkg::CMD_RESERVE: begin
          if (!slot_ok) begin
            st_d = dsa_pkg::ST_BADF;
          end else if (used) begin
            st_d = dsa_pkg::ST_BUSY;
          end else begin
            st_d    = dsa_pkg::ST_OK;
            set_bit = 1'b1;
          end
        end
        dsa_pkg::CMD_RELEASE: begin
          if (slot_ok) begin
            st_d    = dsa_pkg::ST_OK;
            clr_bit = 1'b1;
            mem_we  = 1'b1;
            wdata   = '0;
            prior_d = dsa_pkg::HANDLEF_W'(rd_q);
          end
        end
        dsa_pkg::CMD_INSTALL: begin
          if (slot_ok && !hin_zero) begin
            st_d    = dsa_pkg::ST_OK;
            mem_we  = 1'b1;
            prior_d = dsa_pkg::HANDLEF_W'(rd_q);
          end
        end
        dsa_pkg::CMD_LOOKUP: begin
          if (slot_ok && used) hout_d = dsa_pkg::HANDLEF_W'(rd_q);
          st_d = (hout_d == '0) ? dsa_pkg::ST_BADF : dsa_pkg::ST_OK;
        end
        default: begin
          st_d = dsa_pkg::ST_BADF;
        end
      endcase
    end
  end

  // Request capture and search registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q     <= dsa_pkg::cmd_e'(command_i);
      ctx_ok_q  <= int'(context_req_i) < dsa_pkg::CONTEXTS;
      ctx_q     <= ctx_idx;
      slot_in_q <= slot_in_i;
      hin_q     <= dsa_pkg::HANDLE_BITS'(handle_in_i);
      row_q     <= row_pad;
      for (int g = 0; g < dsa_pkg::GROUPS; g++) begin
        gfree_q[g] <= ~&row_pad[g * dsa_pkg::GROUP_W +: dsa_pkg::GROUP_W];
      end
    end
    if (cmd_i.find) begin
      tgt_q  <= tgt_d;
      full_q <= ~|gfree_q;
    end
  end

  // Handle memory: one read port used in the search cycle, one write port
  // shared by the clearing sweep and the commit cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      handle_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.commit && mem_we) begin
      handle_mem[{ctx_q, tgt_q}] <= wdata;
    end
    if (cmd_i.find) begin
      rd_q <= handle_mem[{ctx_q, tgt_d}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      for (int c = 0; c < dsa_pkg::CONTEXTS; c++) begin
        occ_q[c] <= '0;
      end
    end else begin
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.commit && set_bit) occ_q[ctx_q][tgt_q] <= 1'b1;
      if (cmd_i.commit && clr_bit) occ_q[ctx_q][tgt_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q     <= st_d;
      slot_out_q   <= sout_d;
      handle_out_q <= hout_d;
      prior_q      <= prior_d;
    end
  end

  assign stat_o.clear_last = &clr_cnt_q;
  assign stat_o.out_stall  = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_out_o     = slot_out_q;
  assign handle_out_o   = handle_out_q;
  assign prior_handle_o = prior_q;

endmodule

`default_nettype wire

FILE: rtl/descriptor_slot_allocator.sv
// Top level of the descriptor slot allocator: per-context occupancy bitmaps and
// handle tables. Instantiates dsa_ctrl and dsa_datapath; depends on dsa_pkg.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         in_valid_i / in_ready_o   command_i, context_req_i, slot_in_i,
//                                                  handle_in_i
//   result    out        out_valid_o / out_ready_i status_o, slot_out_o, handle_out_o,
//                                                  prior_handle_o
//
// Each request goes through capture, search and commit. The accept cycle registers the
// request and the context's occupancy row, the next cycle picks the target slot and reads
// its handle from the handle memory, and the commit step writes the memory, updates
// the bitmap and loads the result register. A new request is accepted only once the
// previous one has committed; the read-modify-write of the handle memory sets that limit.
// After reset the block sweeps all MEM_DEPTH (512) handle memory entries to zero, one entry
// per cycle, with in_ready_o low. The occupancy bitmaps clear at once.
// A result waiting in the output register does not block the next request; only the
// commit cycle waits while the result register is still full and not taken.
`timescale 1ns / 1ps
`default_nettype none

module descriptor_slot_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dsa_pkg::CMD_W-1:0]     command_i,
  input  wire logic [dsa_pkg::CTXF_W-1:0]    context_req_i,
  input  wire logic [dsa_pkg::SLOTF_W-1:0]   slot_in_i,
  input  wire logic [dsa_pkg::HANDLEF_W-1:0] handle_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dsa_pkg::STATUS_W-1:0]       status_o,
  output logic [dsa_pkg::SLOTF_W-1:0]        slot_out_o,
  output logic [dsa_pkg::HANDLEF_W-1:0]      handle_out_o,
  output logic [dsa_pkg::HANDLEF_W-1:0]      prior_handle_o
);

  // Control and status between the sequencer and the datapath.
  dsa_pkg::dp_cmd_t  dp_cmd;
  dsa_pkg::dp_stat_t dp_stat;

  // The controller walks each request through capture, search and commit.
  dsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // The datapath holds the tables, the search logic and the result register.
  dsa_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .command_i      (command_i),
    .context_req_i  (context_req_i),
    .slot_in_i      (slot_in_i),
    .handle_in_i    (handle_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_out_o     (slot_out_o),
    .handle_out_o   (handle_out_o),
    .prior_handle_o (prior_handle_o)
  );

endmodule

`default_nettype wire

FILE: rtl/dsa_checker.sv
// Port-level checker for the descriptor slot allocator, bound to the top level.
// Depends on dsa_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module dsa_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [dsa_pkg::STATUS_W-1:0]  status_o,
  input wire logic [dsa_pkg::SLOTF_W-1:0]   slot_out_o,
  input wire logic [dsa_pkg::HANDLEF_W-1:0] handle_out_o,
  input wire logic [dsa_pkg::HANDLEF_W-1:0] prior_handle_o
);

  // A held result keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(slot_out_o) && $stable(handle_out_o) && $stable(prior_handle_o))
    else $error("result changed while stalled");

  // One request is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // A full table or a busy slot carries no slot and no handles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == dsa_pkg::ST_FULL || status_o == dsa_pkg::ST_BUSY)
      |-> slot_out_o == '0 && handle_out_o == '0 && prior_handle_o == '0)
    else $error("failed request carries data");

  // A found handle always comes with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && handle_out_o != '0 |-> status_o == dsa_pkg::ST_OK)
    else $error("lookup handle with bad status");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .slot_out_o     (slot_out_o),
  .handle_out_o   (handle_out_o),
  .prior_handle_o (prior_handle_o)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for descriptor_slot_allocator: random and directed requests,
// with a built-in predictor of the per-context slot tables. Depends on dsa_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import dsa_pkg::*;

  // Command codes the block does not define; it must answer them as a bad descriptor.
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  localparam int REQUEST_GOAL = 1050;  // roughly how many requests the run sends
  localparam int TAIL_ITEMS   = 100;   // the last requests go out with no idling
  localparam int IDLE_LIMIT   = 4000;  // cycles without any handshake before giving up
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [CTXF_W-1:0]    ctx;
    logic [SLOTF_W-1:0]   slot;
    logic [HANDLEF_W-1:0] handle;
    bit                   drain;  // hold this request until all earlier results are back
  } slot_request_t;

  typedef struct {
    status_e              status;
    logic [SLOTF_W-1:0]   slot;
    logic [HANDLEF_W-1:0] handle;
    logic [HANDLEF_W-1:0] prior;
  } slot_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     command_i = '0;
  logic [CTXF_W-1:0]    context_req_i = '0;
  logic [SLOTF_W-1:0]   slot_in_i = '0;
  logic [HANDLEF_W-1:0] handle_in_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [SLOTF_W-1:0]   slot_out_o;
  logic [HANDLEF_W-1:0] handle_out_o;
  logic [HANDLEF_W-1:0] prior_handle_o;

  descriptor_slot_allocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .context_req_i  (context_req_i),
    .slot_in_i      (slot_in_i),
    .handle_in_i    (handle_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_out_o     (slot_out_o),
    .handle_out_o   (handle_out_o),
    .prior_handle_o (prior_handle_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Requests waiting to be sent, and results the block still owes, oldest first.
  slot_request_t request_backlog[$];
  slot_result_t  pending_results[$];

  // Our own copy of the tables: one occupancy bitmap and one handle row per context.
  logic [SLOTS-1:0]       occupancy_map[CONTEXTS];
  logic [HANDLE_BITS-1:0] handle_table[CONTEXTS][SLOTS];

  // Both counters move by nonblocking assignment, so the driver and the monitor see
  // the same values at any edge no matter which of them runs first.
  int unsigned requests_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned status_tally[4] = '{default: 0};

  bit wind_down = 1'b0;  // set near the end of the run: no more idling on either side
  bit tx_smooth = 1'b0;  // the sender is in a stretch without gaps
  bit rx_smooth = 1'b0;  // the receiver is in a stretch without stalls
  int send_gap = 0;
  int recv_stall = 0;
  int idle_cycles = 0;

  // Applies one command to the table copy and returns the result the block must give.
  // Alloc and alloc-install scan for the lowest free slot; a zero handle on either
  // install flavor is refused before anything is allocated or written.
  function automatic slot_result_t apply_table_command(logic [CMD_W-1:0] cmd,
                                                       logic [CTXF_W-1:0] ctx,
                                                       logic [SLOTF_W-1:0] slot,
                                                       logic [HANDLEF_W-1:0] hin);
    slot_result_t r;
    int           lowest;
    bit           slot_ok;
    logic [HANDLE_BITS-1:0] hval;
    r = '{status: ST_OK, slot: '0, handle: '0, prior: '0};
    hval = hin[HANDLE_BITS-1:0];
    slot_ok = int'(slot) < SLOTS;
    if (int'(ctx) >= CONTEXTS) begin
      r.status = ST_BADF;
    end else begin
      lowest = -1;
      for (int s = SLOTS - 1; s >= 0; s--) begin
        if (!occupancy_map[ctx][s]) lowest = s;
      end
      case (cmd)
        CMD_ALLOC, CMD_ALLOC_INSTALL: begin
          if (cmd == CMD_ALLOC_INSTALL && hval == '0) begin
            r.status = ST_BADF;
          end else if (lowest < 0) begin
            r.status = ST_FULL;
          end else begin
            occupancy_map[ctx][lowest] = 1'b1;
            r.slot = lowest[SLOTF_W-1:0];
            if (cmd == CMD_ALLOC_INSTALL) begin
              r.prior = handle_table[ctx][lowest];
              handle_table[ctx][lowest] = hval;
            end
          end
        end
        CMD_RESERVE: begin
          if (!slot_ok) r.status = ST_BADF;
          else if (occupancy_map[ctx][slot]) r.status = ST_BUSY;
          else occupancy_map[ctx][slot] = 1'b1;
        end
        CMD_RELEASE: begin
          // Releasing a slot that is already free is not an error.
          if (!slot_ok) begin
            r.status = ST_BADF;
          end else begin
            occupancy_map[ctx][slot] = 1'b0;
            r.prior = handle_table[ctx][slot];
            handle_table[ctx][slot] = '0;
          end
        end
        CMD_INSTALL: begin
          // Install leaves the occupancy bit alone, even on a free slot.
          if (!slot_ok || hval == '0) begin
            r.status = ST_BADF;
          end else begin
            r.prior = handle_table[ctx][slot];
            handle_table[ctx][slot] = hval;
          end
        end
        CMD_LOOKUP: begin
          // A free slot and a used slot with no handle both read as a bad descriptor.
          if (slot_ok && occupancy_map[ctx][slot]) r.handle = handle_table[ctx][slot];
          if (r.handle == '0) r.status = ST_BADF;
        end
        default: r.status = ST_BADF;
      endcase
    end
    status_tally[r.status]++;
    return r;
  endfunction

  task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [CTXF_W-1:0] ctx,
                               input logic [SLOTF_W-1:0] slot,
                               input logic [HANDLEF_W-1:0] handle, input bit drain = 1'b0);
    request_backlog.push_back('{cmd: cmd, ctx: ctx, slot: slot, handle: handle, drain: drain});
  endtask

  // Handles lean toward the corner values: none, all ones and single bits.
  function automatic logic [HANDLEF_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {{(HANDLEF_W-1){1'b0}}, 1'b1} << $urandom_range(0, HANDLEF_W - 1);
      default: return $urandom();
    endcase
  endfunction

  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Driver. A request on the port stays put until it is taken; only then may the
  // valid drop for a gap or the next request go out. The prediction is made at the
  // edge where the block takes the request, so results line up in acceptance order.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    slot_request_t next_req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
      for (int c = 0; c < CONTEXTS; c++) begin
        occupancy_map[c] = '0;
        for (int s = 0; s < SLOTS; s++) handle_table[c][s] = '0;
      end
    end else begin
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(apply_table_command(command_i, context_req_i,
                                                      slot_in_i, handle_in_i));
        requests_taken <= requests_taken + 1;
        if (requests_taken % 64 == 63) tx_smooth <= ($urandom_range(0, 2) == 0);
      end
      wind_down <= (request_backlog.size() < TAIL_ITEMS);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (request_backlog.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (request_backlog[0].drain &&
                     (in_valid_i || requests_taken != results_seen)) begin
          // Pause the sender until the block has handed back every result it owes.
          in_valid_i <= 1'b0;
        end else if (!wind_down && !tx_smooth && $urandom_range(0, 5) == 0) begin
          // This cycle opens a gap of random length in the requests.
          send_gap   <= $urandom_range(0, 16);
          in_valid_i <= 1'b0;
        end else begin
          next_req      = request_backlog.pop_front();
          in_valid_i    <= 1'b1;
          command_i     <= next_req.cmd;
          context_req_i <= next_req.ctx;
          slot_in_i     <= next_req.slot;
          handle_in_i   <= next_req.handle;
        end
      end
    end
  end

  // Monitor. Checks each result taken against the oldest prediction, field by field,
  // and drives out_ready_i with stall bursts of random length.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    slot_result_t due;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (results_seen % 50 == 49) rx_smooth <= ($urandom_range(0, 2) == 0);
        if (results_seen >= requests_taken) begin
          log_mismatch($sformatf("result with none outstanding: status %0d slot %0d %s",
                                 status_o, slot_out_o,
                                 $sformatf("handle %h prior %h", handle_out_o,
                                           prior_handle_o)));
        end else begin
          due = pending_results.pop_front();
          if (status_o !== due.status)
            log_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                   results_seen, due.status, status_o));
          if (slot_out_o !== due.slot)
            log_mismatch($sformatf("result %0d slot: expected %0d, got %0d",
                                   results_seen, due.slot, slot_out_o));
          if (handle_out_o !== due.handle)
            log_mismatch($sformatf("result %0d handle: expected %h, got %h",
                                   results_seen, due.handle, handle_out_o));
          if (prior_handle_o !== due.prior)
            log_mismatch($sformatf("result %0d prior handle: expected %h, got %h",
                                   results_seen, due.prior, prior_handle_o));
        end
      end
      if (recv_stall != 0) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if (!wind_down && !rx_smooth && $urandom_range(0, 9) == 0) begin
        recv_stall  <= $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog. The clearing sweep after reset fits well inside the limit, as do the longest
  // gap, the longest stall and a full drain pause together.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results still owed",
               idle_cycles, requests_taken - results_seen);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int kind;
    int ctx;
    int base;
    int len;
    int fills;
    bit as_install;
    fills = 0;

    // Directed part: empty-table lookups, free-slot release, zero handles, the lowest
    // free slot being reused, busy reserve, handle replacement, undefined commands.
    queue_request(CMD_LOOKUP, 7, 63, 32'hDEAD_BEEF);
    queue_request(CMD_RELEASE, 7, 63, '0);
    queue_request(CMD_INSTALL, 0, 5, '0);
    queue_request(CMD_ALLOC_INSTALL, 0, 0, '0);
    queue_request(CMD_ALLOC, 0, 63, '1);
    queue_request(CMD_ALLOC_INSTALL, 0, 0, '1);
    queue_request(CMD_LOOKUP, 0, 1, '0);
    queue_request(CMD_LOOKUP, 0, 0, '0);
    queue_request(CMD_RESERVE, 0, 0, '0);
    queue_request(CMD_RESERVE, 0, 63, '0);
    queue_request(CMD_INSTALL, 0, 63, 32'h0000_0001);
    queue_request(CMD_INSTALL, 0, 63, 32'h8000_0000);
    queue_request(CMD_LOOKUP, 0, 63, '0);
    queue_request(CMD_INSTALL, 0, 2, 32'hA5A5_A5A5);
    queue_request(CMD_LOOKUP, 0, 2, '0);
    queue_request(CMD_ALLOC_INSTALL, 0, 0, 32'h5A5A_5A5A);
    queue_request(CMD_UNDEF_LO, 1, 0, 32'h0000_0001);
    queue_request(CMD_UNDEF_HI, 7, 63, '1);
    queue_request(CMD_RELEASE, 0, 63, '0);
    queue_request(CMD_RELEASE, 0, 1, '0);
    queue_request(CMD_ALLOC, 0, 0, '0);
    queue_request(CMD_RESERVE, 7, 63, '0);
    queue_request(CMD_ALLOC_INSTALL, 7, 0, '1);
    queue_request(CMD_LOOKUP, 7, 63, '0);

    // Random part, built from short sequences. The first is a fill of one table up to
    // full and past it, sent only after the directed results have all come back.
    kind = 0;
    while (request_backlog.size() < REQUEST_GOAL) begin
      if (kind != 0 || fills == 0) kind = (fills == 0) ? 0 : $urandom_range(0, 9);
      if (kind == 0 && fills < 4) begin
        // Fill: SLOTS + 2 allocations in one context, aimed at filling the table and running past it.
        ctx = $urandom_range(0, CONTEXTS - 1);
        for (int i = 0; i < SLOTS + 2; i++) begin
          as_install = ($urandom_range(0, 1) != 0);
          queue_request(as_install ? CMD_ALLOC_INSTALL : CMD_ALLOC, CTXF_W'(ctx),
                        SLOTF_W'($urandom_range(0, SLOTS - 1)), pick_handle(),
                        fills == 0 && i == 0);
        end
        fills++;
      end else if (kind <= 6) begin
        // Churn: every command on a small window of slots, so hits on used slots,
        // busy reserves and handle replacement are common.
        ctx  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CONTEXTS - 1)
                                           : $urandom_range(0, 2);
        base = $urandom_range(0, 1) ? 0 : SLOTS - 8;
        len  = $urandom_range(8, 20);
        for (int i = 0; i < len; i++) begin
          queue_request(CMD_W'($urandom_range(CMD_ALLOC, CMD_ALLOC_INSTALL)), CTXF_W'(ctx),
                        SLOTF_W'(base + $urandom_range(0, 7)), pick_handle(),
                        i == 0 && $urandom_range(0, 29) == 0);
        end
      end else if (kind == 7) begin
        // One slot's whole life: reserve, install, look up, release, look up again.
        ctx  = $urandom_range(0, CONTEXTS - 1);
        base = $urandom_range(0, SLOTS - 1);
        queue_request(CMD_RESERVE, CTXF_W'(ctx), SLOTF_W'(base), $urandom());
        queue_request(CMD_INSTALL, CTXF_W'(ctx), SLOTF_W'(base), pick_handle());
        queue_request(CMD_LOOKUP, CTXF_W'(ctx), SLOTF_W'(base), $urandom());
        queue_request(CMD_RELEASE, CTXF_W'(ctx), SLOTF_W'(base), $urandom());
        queue_request(CMD_LOOKUP, CTXF_W'(ctx), SLOTF_W'(base), $urandom());
      end else begin
        // Noise: any field value, undefined commands included.
        len = $urandom_range(4, 8);
        for (int i = 0; i < len; i++) begin
          queue_request(CMD_W'($urandom_range(0, 7)), CTXF_W'($urandom_range(0, 7)),
                        SLOTF_W'($urandom_range(0, 63)),
                        $urandom_range(0, 1) ? $urandom() : pick_handle());
        end
      end
      kind = 1;
    end

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_backlog.size() != 0 || in_valid_i || requests_taken != results_seen)
      @(posedge clk_i);
    // Run on past the last result so that any result the block should not produce shows up.
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests in %0d table fills plus slot churn, lifecycles and noise;",
             requests_taken, fills);
    $display("checked %0d results (ok %0d, full %0d, busy %0d, bad %0d), %0d mismatches.",
             results_seen, status_tally[ST_OK], status_tally[ST_FULL],
             status_tally[ST_BUSY], status_tally[ST_BADF], mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
